// ===== sv/slot_execution_timeout_watchdog_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Slot watchdog assertion macros
// Shared assertion shorthands for the slot watchdog checkers.
// ----------------------------------------------------------------------------
`ifndef SLOT_EXECUTION_TIMEOUT_WATCHDOG_UNIT_DEFINES_SVH
`define SLOT_EXECUTION_TIMEOUT_WATCHDOG_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SEWD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot watchdog check failed");

// next-cycle implication, sampled on clk, off during reset
`define SEWD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot watchdog check failed");

`endif

// ===== sv/sewd_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot watchdog package
// Field widths, codes, register map and shared types.
// ----------------------------------------------------------------------------
package sewd_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 4;
    localparam int NOW_W    = 32;
    localparam int EV_W     = 2;
    localparam int KILL_W   = 5;

    localparam int TIMEOUT_W = 32;
    localparam int SLOTS_W   = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd5000;
    localparam logic [SLOTS_W-1:0]   SLOTS_RST   = 5'd16;

    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SLOTS   = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACTIVATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET    = 2'd2;

    typedef enum logic [1:0] {
        SLOT_AVAIL  = 2'd0,
        SLOT_ACTIVE = 2'd1,
        SLOT_TERM   = 2'd2
    } slot_state_t;

    typedef enum logic [EV_W-1:0] {
        EV_DONE  = 2'd0,
        EV_KILL  = 2'd1,
        EV_ERROR = 2'd2
    } ev_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [SLOTS_W-1:0]   slots_in_use;
    } cfg_t;

endpackage

// ===== sv/sewd_if.sv =====
// ----------------------------------------------------------------------------
// Slot watchdog channels
// Command channel (one beat per item) and event channel (result beats).
// ----------------------------------------------------------------------------
interface sewd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [sewd_pkg::ACTION_W-1:0] action;
    logic [sewd_pkg::SLOT_W-1:0]   slot;
    logic [sewd_pkg::NOW_W-1:0]    now_ms;

    modport source (output valid, action, slot, now_ms, input ready);
    modport sink   (input valid, action, slot, now_ms, output ready);
endinterface

interface sewd_evt_if;
    logic                        valid;
    logic                        ready;
    logic [sewd_pkg::EV_W-1:0]   event_res;
    logic [sewd_pkg::SLOT_W-1:0] slot_out;
    logic [sewd_pkg::KILL_W-1:0] kill_count;
    logic                        last;

    modport source (output valid, event_res, slot_out, kill_count, last, input ready);
    modport sink   (input valid, event_res, slot_out, kill_count, last, output ready);
endinterface

// ===== sv/slot_execution_timeout_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// Slot execution timeout watchdog
// Per-slot watchdog: activate stamps a start time, reset frees a slot, and a
// tick terminates each active slot under the slot count past the timeout.
// ----------------------------------------------------------------------------
// One command is in flight at a time; cmd.ready drops from acceptance until
// the sequencer is back in idle. Activate and reset pass through one table
// read, then the write-back with the result, before the next acceptance. A
// tick walks the first N entries, N being the effective slot count
// (slots_in_use clipped to NUM_SLOTS): the slot table has a single read port
// and is walked one entry per cycle unless a kill waits on the event register,
// then the closing beat is emitted. Each kill found produces one event beat
// (last=0) followed by the closing beat (event_res=done, kill_count, last=1);
// activate and reset produce a single beat with last=1 (event_res=done or
// error). A result beat sitting unclaimed in the event register only stalls
// the sequencer when it has a new beat to place. All slots read as available
// after reset, with no clearing pass. Elapsed time is computed modulo
// 2^TIME_BITS; kill_count saturates at 31.
// ----------------------------------------------------------------------------
module slot_execution_timeout_watchdog_unit #(
    parameter int NUM_SLOTS = sewd_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = sewd_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sewd_cmd_if.sink                        cmd,
    sewd_evt_if.source                      evt,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sewd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sewd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sewd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sewd_pkg::*;

    // table address width; covers NUM_SLOTS of 1
    localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    cfg_t                 cfg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [1:0]           rd_state;
    logic [TIME_BITS-1:0] rd_time;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [1:0]           wr_state;
    logic [TIME_BITS-1:0] wr_time;

    // timeout and slot-count registers
    sewd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // slot table: state + start time per slot
    sewd_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_state (rd_state),
        .rd_time  (rd_time),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_state (wr_state),
        .wr_time  (wr_time)
    );

    // command sequencer, table walker and event register
    sewd_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .evt      (evt),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_state (rd_state),
        .rd_time  (rd_time),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_state (wr_state),
        .wr_time  (wr_time)
    );

endmodule

// ===== sv/sewd_cfg.sv =====
// ----------------------------------------------------------------------------
// Slot watchdog register file
// APB-style port holding the timeout and slot count registers.
// ----------------------------------------------------------------------------
module sewd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sewd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sewd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sewd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output sewd_pkg::cfg_t                      cfg
);
    import sewd_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [SLOTS_W-1:0]   slots_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_stb;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_stb  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            slots_reg   <= SLOTS_RST;
        end
        else if (wr_stb)
        begin
            unique case (reg_idx)
                REG_TIMEOUT: timeout_reg <= pwdata[TIMEOUT_W-1:0];
                REG_SLOTS:   slots_reg   <= pwdata[SLOTS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TIMEOUT: prdata = CFG_DATA_W'(timeout_reg);
            REG_SLOTS:   prdata = CFG_DATA_W'(slots_reg);
        endcase
    end

    assign cfg.timeout_ms   = timeout_reg;
    assign cfg.slots_in_use = slots_reg;

endmodule

// ===== sv/sewd_mem.sv =====
// ----------------------------------------------------------------------------
// Slot watchdog slot table
// One-port-read, one-port-write table of {state, start time}, with a
// registered read. Per-entry written flags make unwritten slots read available.
// ----------------------------------------------------------------------------
module sewd_mem #(
    parameter int NUM_SLOTS = sewd_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = sewd_pkg::TIME_BITS_DEF,
    parameter int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [1:0]           rd_state,
    output logic [TIME_BITS-1:0] rd_time,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [1:0]           wr_state,
    input  logic [TIME_BITS-1:0] wr_time
);
    import sewd_pkg::*;

    localparam int ENT_W = TIME_BITS + 2;

    logic [ENT_W-1:0]     ram [NUM_SLOTS];
    logic [ENT_W-1:0]     rd_data_reg;
    logic [NUM_SLOTS-1:0] written_reg;
    logic                 rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            ram[wr_addr] <= {wr_state, wr_time};
        if (rd_en)
            rd_data_reg <= ram[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                written_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_written_reg <= written_reg[rd_addr];
        end
    end

    // read data holds while rd_en is low, so a stalled consumer keeps its entry
    assign rd_state = rd_written_reg ? rd_data_reg[ENT_W-1 -: 2] : SLOT_AVAIL;
    assign rd_time  = rd_data_reg[TIME_BITS-1:0];

endmodule

// ===== sv/sewd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Slot watchdog sequencer
// Accepts commands, walks the slot table one entry per cycle on a tick while
// no kill waits on the event register, does read-modify-write for
// activate/reset, and drives the event register.
module sewd_ctrl #(
    parameter int NUM_SLOTS = sewd_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = sewd_pkg::TIME_BITS_DEF,
    parameter int ADDR_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sewd_pkg::cfg_t       cfg,
    sewd_cmd_if.sink             cmd,
    sewd_evt_if.source           evt,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [1:0]           rd_state,
    input  logic [TIME_BITS-1:0] rd_time,
    output logic                 wr_en,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [1:0]           wr_state,
    output logic [TIME_BITS-1:0] wr_time
);
    import sewd_pkg::*;

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SINGLE,
        ST_CLOSE
    } state_t;

    state_t                state_reg,    state_next;
    logic [ACTION_W-1:0]   act_reg,      act_next;
    logic [SLOT_W-1:0]     slot_reg,     slot_next;
    logic [TIME_BITS-1:0]  now_reg,      now_next;
    logic [CNT_W-1:0]      n_reg,        n_next;
    logic [ADDR_W-1:0]     idx_reg,      idx_next;
    logic [KILL_W-1:0]     kills_reg,    kills_next;
    logic                  err_reg,      err_next;
    logic                  ovld_reg,     ovld_next;
    logic [EV_W-1:0]       oev_reg,      oev_next;
    logic [SLOT_W-1:0]     oslot_reg,    oslot_next;
    logic [KILL_W-1:0]     ocnt_reg,     ocnt_next;
    logic                  olast_reg,    olast_next;

    logic                  out_free;
    logic [CNT_W-1:0]      n_eff;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  kill_hit;
    logic                  bad;
    logic [ADDR_W-1:0]     cmd_addr;

    assign out_free = !ovld_reg || evt.ready;
    assign n_eff    = (int'(cfg.slots_in_use) > NUM_SLOTS) ? CNT_W'(NUM_SLOTS)
                                                          : CNT_W'(cfg.slots_in_use);
    assign elapsed  = now_reg - rd_time;
    assign kill_hit = (rd_state == SLOT_ACTIVE) &&
                      (CMP_W'(elapsed) > CMP_W'(cfg.timeout_ms));
    assign bad      = err_reg ||
                      ((act_reg == ACT_ACTIVATE) && (rd_state != SLOT_AVAIL)) ||
                      ((act_reg == ACT_RESET) && (rd_state == SLOT_AVAIL));
    // out-of-table slots are errors anyway; keep the address in range
    assign cmd_addr = (int'(cmd.slot) < NUM_SLOTS) ? ADDR_W'(cmd.slot) : '0;

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign evt.valid      = ovld_reg;
    assign evt.event_res  = oev_reg;
    assign evt.slot_out   = oslot_reg;
    assign evt.kill_count = ocnt_reg;
    assign evt.last       = olast_reg;

    // Reads and writes never hit the same entry in one cycle: a scan writes
    // entry i while reading i+1, and activate/reset write after their read.
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        slot_next  = slot_reg;
        now_next   = now_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        kills_next = kills_reg;
        err_next   = err_reg;
        ovld_next  = ovld_reg && !evt.ready;
        oev_next   = oev_reg;
        oslot_next = oslot_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_state   = rd_state;
        wr_time    = rd_time;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next   = cmd.action;
                    slot_next  = cmd.slot;
                    now_next   = TIME_BITS'(cmd.now_ms);
                    n_next     = n_eff;
                    kills_next = '0;
                    idx_next   = '0;
                    err_next   = !((cmd.action == ACT_ACTIVATE) || (cmd.action == ACT_RESET))
                                 || (CNT_W'(cmd.slot) >= n_eff)
                                 || (int'(cmd.slot) >= int'(n_eff));
                    if (cmd.action == ACT_TICK)
                    begin
                        if (n_eff == '0)
                            state_next = ST_CLOSE;
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cmd_addr;
                        state_next = ST_SINGLE;
                    end
                end
            end

            ST_SCAN:
            begin
                // a kill waits for the event register; other slots never stall
                if (!kill_hit || out_free)
                begin
                    if (kill_hit)
                    begin
                        wr_en      = 1'b1;
                        wr_state   = SLOT_TERM;
                        ovld_next  = 1'b1;
                        oev_next   = EV_KILL;
                        oslot_next = SLOT_W'(idx_reg);
                        ocnt_next  = '0;
                        olast_next = 1'b0;
                        kills_next = (kills_reg == '1) ? kills_reg : kills_reg + KILL_W'(1);
                    end
                    if (CNT_W'(idx_reg) + CNT_W'(1) == n_reg)
                        state_next = ST_CLOSE;
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                    end
                end
            end

            ST_SINGLE:
            begin
                if (out_free)
                begin
                    if (!bad)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(slot_reg);
                        if (act_reg == ACT_ACTIVATE)
                        begin
                            wr_state = SLOT_ACTIVE;
                            wr_time  = now_reg;
                        end
                        else
                            wr_state = SLOT_AVAIL;
                    end
                    ovld_next  = 1'b1;
                    oev_next   = bad ? EV_ERROR : EV_DONE;
                    oslot_next = slot_reg;
                    ocnt_next  = '0;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_CLOSE:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    oev_next   = EV_DONE;
                    oslot_next = '0;
                    ocnt_next  = kills_reg;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            act_reg   <= ACT_TICK;
            slot_reg  <= '0;
            now_reg   <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            kills_reg <= '0;
            err_reg   <= 1'b0;
            ovld_reg  <= 1'b0;
            oev_reg   <= EV_DONE;
            oslot_reg <= '0;
            ocnt_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            slot_reg  <= slot_next;
            now_reg   <= now_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            kills_reg <= kills_next;
            err_reg   <= err_next;
            ovld_reg  <= ovld_next;
            oev_reg   <= oev_next;
            oslot_reg <= oslot_next;
            ocnt_reg  <= ocnt_next;
            olast_reg <= olast_next;
        end
    end

endmodule

// ===== sv/sewd_chk.sv =====
// ----------------------------------------------------------------------------
// Slot watchdog port checker
// Watches the command and event ports of the watchdog top level.
// ----------------------------------------------------------------------------
`include "slot_execution_timeout_watchdog_unit_defines.svh"

module sewd_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          evt_valid,
    input logic                          evt_ready,
    input logic [sewd_pkg::EV_W-1:0]     evt_event_res,
    input logic [sewd_pkg::SLOT_W-1:0]   evt_slot_out,
    input logic [sewd_pkg::KILL_W-1:0]   evt_kill_count,
    input logic                          evt_last
);
    import sewd_pkg::*;

    // a stalled event beat holds
    `SEWD_ASSERT_NXT(a_evt_hold, evt_valid && !evt_ready, evt_valid && $stable(evt_event_res) && $stable(evt_slot_out) && $stable(evt_kill_count) && $stable(evt_last))

    // one command in flight: ready drops right after a beat is taken
    `SEWD_ASSERT_NXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready)

    // kill beats are never the closing beat and carry no count
    `SEWD_ASSERT_IMP(a_kill_beat, evt_valid && evt_event_res == EV_KILL, !evt_last && evt_kill_count == '0)

    // errors are single closing beats
    `SEWD_ASSERT_IMP(a_err_beat, evt_valid && evt_event_res == EV_ERROR, evt_last && evt_kill_count == '0)

    // a count only shows on a tick's closing beat
    `SEWD_ASSERT_IMP(a_count_beat, evt_valid && evt_kill_count != '0, evt_last && evt_event_res == EV_DONE)

endmodule

bind slot_execution_timeout_watchdog_unit sewd_chk u_sewd_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .evt_valid      (evt.valid),
    .evt_ready      (evt.ready),
    .evt_event_res  (evt.event_res),
    .evt_slot_out   (evt.slot_out),
    .evt_kill_count (evt.kill_count),
    .evt_last       (evt.last)
);
